>>> hdl/gsgs_pkg.sv
// ----------------------------------------------------------------------------
// gsgs_pkg
// Shared types and constants of the generational slot group store.
// ----------------------------------------------------------------------------
package gsgs_pkg;

    localparam int SLOT_COUNT_DEF       = 64;
    localparam int MEMBERS_PER_SLOT_DEF = 8;
    localparam int GEN_BITS_DEF         = 16;

    localparam int MODE_W  = 3;
    localparam int INDEX_W = 6;
    localparam int GEN_W   = 16;
    localparam int AGENT_W = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE   = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_VALIDATE = 3'd2,
        MODE_ADD      = 3'd3,
        MODE_DROP     = 3'd4,
        MODE_FIND     = 3'd5
    } mode_t;

    typedef struct packed {
        logic load;
        logic read;
        logic advance;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_mode;
        logic scan_hit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

>>> hdl/gsgs_ifs.sv
// ----------------------------------------------------------------------------
// gsgs_in_if / gsgs_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsgs_in_if;
    logic                          valid;
    logic                          ready;
    logic [gsgs_pkg::MODE_W-1:0]   mode;
    logic [gsgs_pkg::INDEX_W-1:0]  group_index;
    logic [gsgs_pkg::GEN_W-1:0]    group_generation;
    logic [gsgs_pkg::AGENT_W-1:0]  agent_id;

    modport source (output valid, mode, group_index, group_generation, agent_id,
                    input ready);
    modport sink   (input valid, mode, group_index, group_generation, agent_id,
                    output ready);
endinterface

interface gsgs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [gsgs_pkg::INDEX_W-1:0]  out_index;
    logic [gsgs_pkg::GEN_W-1:0]    out_generation;
    logic [gsgs_pkg::COUNT_W-1:0]  live_count;

    modport source (output valid, ok, out_index, out_generation, live_count,
                    input ready);
    modport sink   (input valid, ok, out_index, out_generation, live_count,
                    output ready);
endinterface

>>> hdl/gsgs_ctrl.sv
// ----------------------------------------------------------------------------
// gsgs_ctrl
// Sequencer: accept a request, read slot rows, scan or finish.
// ----------------------------------------------------------------------------
module gsgs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gsgs_pkg::dp_status_t  status,
    output gsgs_pkg::ctrl_cmd_t   cmd
);
    import gsgs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.scan_mode && !status.scan_hit && !status.last)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
                else if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/gsgs_dp.sv
// ----------------------------------------------------------------------------
// gsgs_dp
// Slot row memory, row valid flags, request latch, live count and result
// register.
// ----------------------------------------------------------------------------
module gsgs_dp #(
    parameter int SLOT_COUNT       = gsgs_pkg::SLOT_COUNT_DEF,
    parameter int MEMBERS_PER_SLOT = gsgs_pkg::MEMBERS_PER_SLOT_DEF,
    parameter int GEN_BITS         = gsgs_pkg::GEN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gsgs_pkg::ctrl_cmd_t           cmd,
    output gsgs_pkg::dp_status_t          status,
    input  logic [gsgs_pkg::MODE_W-1:0]   mode,
    input  logic [gsgs_pkg::INDEX_W-1:0]  group_index,
    input  logic [gsgs_pkg::GEN_W-1:0]    group_generation,
    input  logic [gsgs_pkg::AGENT_W-1:0]  agent_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [gsgs_pkg::INDEX_W-1:0]  out_index,
    output logic [gsgs_pkg::GEN_W-1:0]    out_generation,
    output logic [gsgs_pkg::COUNT_W-1:0]  live_count
);
    import gsgs_pkg::*;

    localparam int IW  = $clog2(SLOT_COUNT);
    localparam int M   = MEMBERS_PER_SLOT;
    localparam int VW  = M * AGENT_W;
    localparam int RW  = 1 + GEN_BITS + M + VW;
    localparam int CW  = (GEN_BITS > GEN_W) ? GEN_BITS : GEN_W;

    logic [RW-1:0]         mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] row_valid_reg;
    logic [RW-1:0]         q_reg;
    logic                  qv_reg;

    logic [MODE_W-1:0]     mode_reg;
    logic [INDEX_W-1:0]    idx_reg;
    logic [GEN_W-1:0]      gen_reg;
    logic [AGENT_W-1:0]    agent_reg;
    logic [IW-1:0]         ptr_reg, ptr_next;
    logic [IW-1:0]         total_reg, total_next;

    logic                  out_valid_reg;
    logic                  ok_reg, ok_next;
    logic [INDEX_W-1:0]    oidx_reg, oidx_next;
    logic [GEN_W-1:0]      ogen_reg, ogen_next;

    logic                  busy;
    logic [GEN_BITS-1:0]   gen;
    logic [GEN_BITS-1:0]   gen_inc;
    logic [M-1:0]          mask;
    logic [VW-1:0]         vals;
    logic [M-1:0]          hit;
    logic [M-1:0]          free_1h;
    logic                  free_any;
    logic                  idx_ok;
    logic                  live;
    logic                  agent_nz;
    logic                  is_scan;
    logic                  wr_en;
    logic [RW-1:0]         wr_row;

    assign busy     = qv_reg & q_reg[RW-1];
    assign gen      = qv_reg ? q_reg[RW-2 -: GEN_BITS] : GEN_BITS'(1);
    assign mask     = qv_reg ? q_reg[VW +: M] : '0;
    assign vals     = q_reg[VW-1:0];
    assign agent_nz = (agent_reg != '0);
    assign idx_ok   = (idx_reg != '0) && (32'(idx_reg) < 32'(SLOT_COUNT));
    assign live     = idx_ok && busy && (CW'(gen) == CW'(gen_reg));
    assign is_scan  = (mode_reg == MODE_CREATE) || (mode_reg == MODE_FIND);

    always_comb
    begin
        gen_inc = gen + GEN_BITS'(1);
        if (gen_inc == '0)
        begin
            gen_inc = GEN_BITS'(1);
        end
    end

    always_comb
    begin
        logic found;
        found   = 1'b0;
        free_1h = '0;
        for (int k = 0; k < M; k++)
        begin
            hit[k] = mask[k] && (vals[k*AGENT_W +: AGENT_W] == agent_reg);
            if (!mask[k] && !found)
            begin
                free_1h[k] = 1'b1;
                found      = 1'b1;
            end
        end
        free_any = found;
    end

    assign status.scan_mode = is_scan;
    assign status.scan_hit  = ((mode_reg == MODE_CREATE) && !busy)
                           || ((mode_reg == MODE_FIND) && busy && agent_nz && (hit != '0));
    assign status.last      = (ptr_reg == IW'(SLOT_COUNT - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_row     = {busy, gen, mask, vals};
        ok_next    = 1'b0;
        oidx_next  = '0;
        ogen_next  = '0;
        total_next = total_reg;
        unique case (mode_reg)
            MODE_CREATE:
            begin
                if (!busy)
                begin
                    wr_en      = 1'b1;
                    wr_row     = {1'b1, gen, {M{1'b0}}, vals};
                    total_next = total_reg + IW'(1);
                    ok_next    = 1'b1;
                    oidx_next  = INDEX_W'(ptr_reg);
                    ogen_next  = GEN_W'(gen);
                end
            end
            MODE_REMOVE:
            begin
                if (live)
                begin
                    wr_en      = 1'b1;
                    wr_row     = {1'b0, gen_inc, {M{1'b0}}, vals};
                    total_next = total_reg - IW'(1);
                    ok_next    = 1'b1;
                end
            end
            MODE_VALIDATE:
            begin
                ok_next = live;
            end
            MODE_ADD:
            begin
                if (live && agent_nz)
                begin
                    if (hit != '0)
                    begin
                        ok_next = 1'b1;
                    end
                    else if (free_any)
                    begin
                        wr_en   = 1'b1;
                        ok_next = 1'b1;
                        wr_row[VW +: M] = mask | free_1h;
                        for (int k = 0; k < M; k++)
                        begin
                            if (free_1h[k])
                            begin
                                wr_row[k*AGENT_W +: AGENT_W] = agent_reg;
                            end
                        end
                    end
                end
            end
            MODE_DROP:
            begin
                if (live && (hit != '0))
                begin
                    wr_en           = 1'b1;
                    ok_next         = 1'b1;
                    wr_row[VW +: M] = mask & ~hit;
                end
            end
            MODE_FIND:
            begin
                if (busy && agent_nz && (hit != '0))
                begin
                    ok_next   = 1'b1;
                    oidx_next = INDEX_W'(ptr_reg);
                    ogen_next = GEN_W'(gen);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            if ((mode == MODE_CREATE) || (mode == MODE_FIND))
            begin
                ptr_next = IW'(1);
            end
            else
            begin
                ptr_next = IW'(group_index);
            end
        end
        else if (cmd.advance)
        begin
            ptr_next = ptr_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            idx_reg   <= group_index;
            gen_reg   <= group_generation;
            agent_reg <= agent_id;
        end
        if (cmd.read)
        begin
            q_reg <= mem[ptr_reg];
        end
        if (cmd.finish && wr_en)
        begin
            mem[ptr_reg] <= wr_row;
        end
        if (cmd.finish)
        begin
            ok_reg   <= ok_next;
            oidx_reg <= oidx_next;
            ogen_reg <= ogen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            qv_reg        <= 1'b0;
            ptr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.read)
            begin
                qv_reg <= row_valid_reg[ptr_reg];
            end
            if (cmd.finish)
            begin
                total_reg <= total_next;
                if (wr_en)
                begin
                    row_valid_reg[ptr_reg] <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign live_count     = COUNT_W'(total_reg);

endmodule

>>> hdl/generational_slot_group_store.sv
// ----------------------------------------------------------------------------
// generational_slot_group_store
// Table of group slots addressed by generational handles.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: mode, group_index,
//   group_generation and agent_id. out_ch returns one result transaction
//   per request: ok, out_index, out_generation and live_count.
//   Each slot row (busy flag, generation, member mask, member ids) lives in
//   one memory read one row per access; a row visit passes READ, then CHECK.
//   Remove, validate, add member and remove member touch one row: the
//   request is latched on accept, the row is read in READ and the result
//   is registered in CHECK once out_ch is free.
//   Create and find scan rows from slot 1 up to slot SLOT_COUNT-1, a READ
//   and a CHECK per slot, stopping at the first free slot or match.
//   One request is in flight at a time; a new one is taken as soon as the
//   previous result has been registered, while that result still waits.
//   Reset clears every row flag: all slots read as free, generation one,
//   no members. No clearing pass is needed.
//   A stalled out_ch holds the result and the block waits before finishing
//   the next request.
// ----------------------------------------------------------------------------
module generational_slot_group_store #(
    parameter int SLOT_COUNT       = gsgs_pkg::SLOT_COUNT_DEF,
    parameter int MEMBERS_PER_SLOT = gsgs_pkg::MEMBERS_PER_SLOT_DEF,
    parameter int GEN_BITS         = gsgs_pkg::GEN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gsgs_in_if.sink     in_ch,
    gsgs_out_if.source  out_ch
);
    import gsgs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gsgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gsgs_dp #(
        .SLOT_COUNT       (SLOT_COUNT),
        .MEMBERS_PER_SLOT (MEMBERS_PER_SLOT),
        .GEN_BITS         (GEN_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .mode             (in_ch.mode),
        .group_index      (in_ch.group_index),
        .group_generation (in_ch.group_generation),
        .agent_id         (in_ch.agent_id),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .ok               (out_ch.ok),
        .out_index        (out_ch.out_index),
        .out_generation   (out_ch.out_generation),
        .live_count       (out_ch.live_count)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request taken while another is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (32'(out_ch.live_count) <= SLOT_COUNT - 1))
        else $error("live count beyond slot table");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ok && (out_ch.out_index != '0) && (GEN_BITS <= GEN_W))
        |-> (out_ch.out_generation != '0))
        else $error("live group reported with generation zero");

    a_index_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ok) |-> (out_ch.out_index == '0))
        else $error("slot index reported on failure");
`endif

endmodule
